/* hdl/lease_slot_allocator_with_waitlist_top_defines.svh */
// assertion macros for the lease slot allocator checker
// included by the checker file only, needs no other file
`ifndef LEASE_SLOT_ALLOCATOR_WITH_WAITLIST_TOP_DEFINES_SVH
`define LEASE_SLOT_ALLOCATOR_WITH_WAITLIST_TOP_DEFINES_SVH

// same-cycle implication
`define LSAW_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LSAW_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/lsaw_pkg.sv */
// shared types, codes and constants of the lease slot allocator
// used by every module of the block, depends on nothing
package lsaw_pkg;

    localparam int ORDER_W   = 31;
    localparam int REQ_W     = 2;
    localparam int ACT_W     = 3;
    localparam int AGE_W     = 16;
    localparam int LOCK_W    = 3;
    localparam int SLOT_OUT_W = 2;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 40;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    localparam logic [AGE_W-1:0]  AGE_MAX     = 16'hFFFF;
    localparam logic [LOCK_W-1:0] LOCKERS_RST = 3'd4;
    localparam logic [AGE_W-1:0]  LEASE_RST   = 16'd3600;

    localparam logic [REQ_W-1:0] REQ_TICK    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ASSIGN  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_RELEASE = 2'd2;

    localparam logic [ACT_W-1:0] ACT_RELEASED = 3'd0;
    localparam logic [ACT_W-1:0] ACT_ASSIGNED = 3'd1;
    localparam logic [ACT_W-1:0] ACT_QUEUED   = 3'd2;
    localparam logic [ACT_W-1:0] ACT_DROPPED  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_NO_SLOT  = 3'd4;

    localparam logic REG_LOCKERS = 1'b0;
    localparam logic REG_LEASE   = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_DRAIN
    } lsaw_state_t;

    typedef struct packed {
        logic [LOCK_W-1:0] lockers;
        logic [AGE_W-1:0]  lease;
    } lsaw_cfg_t;

    typedef struct packed {
        logic do_req;
        logic do_drain;
    } lsaw_cmd_t;

    typedef struct packed {
        logic [1:0] need;
        logic [1:0] space;
    } lsaw_stat_t;

    typedef struct packed {
        logic [ACT_W-1:0]      action;
        logic [SLOT_OUT_W-1:0] slot_index;
        logic [ORDER_W-1:0]    result_order;
        logic                  open_pulse;
        logic                  notify;
        logic                  last;
    } lsaw_res_t;

endpackage

/* hdl/lease_slot_allocator_with_waitlist_top.sv */
// an accepted beat's results are staged in lsaw_dp, then pushed to the
// result queue in the drain state; no new beat is taken before that, and
// the drain state holds while the two-entry result queue lacks room for them
// reset: aresetn synchronous active low, frees all slots, empties the
// waitlist and result queue, restores lockers_in_use 4 and lease_ticks 3600
module lease_slot_allocator_with_waitlist_top
    import lsaw_pkg::*;
#(
    parameter int SLOTS      = 4,
    parameter int WAIT_DEPTH = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // s_tdata: order_num[30:0]
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // s_tuser: req_type[1:0]
    input  logic [REQ_W-1:0]      s_tuser,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // m_tdata: slot_index[1:0], result_order[32:2], open_pulse[33], notify[34]
    output logic [M_TDATA_W-1:0]  m_tdata,
    // m_tuser: action[2:0]
    output logic [ACT_W-1:0]      m_tuser,
    output logic                  m_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_AW-1:0]     paddr,
    input  logic [APB_DW-1:0]     pwdata,
    output logic [APB_DW-1:0]     prdata,
    output logic                  pready
);

    logic [LOCK_W-1:0] lockers_reg, lockers_next;
    logic [AGE_W-1:0]  lease_reg, lease_next;
    lsaw_cfg_t         cfg;
    lsaw_cmd_t         cmd;
    lsaw_stat_t        stat;
    logic [1:0]        push_need;
    logic [1:0]        space;
    lsaw_res_t         push_res0, push_res1, out_res;

    assign pready = 1'b1;

    always_comb begin
        lockers_next = lockers_reg;
        lease_next   = lease_reg;
        if (psel && penable && pwrite && pready) begin
            unique case (paddr[2])
                REG_LOCKERS: lockers_next = pwdata[LOCK_W-1:0];
                REG_LEASE:   lease_next   = pwdata[AGE_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_LOCKERS: prdata = {{(APB_DW - LOCK_W){1'b0}}, lockers_reg};
            REG_LEASE:   prdata = {{(APB_DW - AGE_W){1'b0}}, lease_reg};
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lockers_reg <= LOCKERS_RST;
            lease_reg   <= LEASE_RST;
        end else begin
            lockers_reg <= lockers_next;
            lease_reg   <= lease_next;
        end
    end

    assign cfg.lockers = lockers_reg;
    assign cfg.lease   = lease_reg;
    assign stat.need   = push_need;
    assign stat.space  = space;

    lsaw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lsaw_dp #(
        .SLOTS      (SLOTS),
        .WAIT_DEPTH (WAIT_DEPTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .cfg       (cfg),
        .in_req    (s_tuser),
        .in_order  (s_tdata[ORDER_W-1:0]),
        .push_need (push_need),
        .push_res0 (push_res0),
        .push_res1 (push_res1)
    );

    lsaw_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_en   (cmd.do_drain),
        .push_cnt  (push_need),
        .push_res0 (push_res0),
        .push_res1 (push_res1),
        .space     (space),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_res     (out_res)
    );

    assign m_tdata = {{(M_TDATA_W - SLOT_OUT_W - ORDER_W - 2){1'b0}},
                      out_res.notify, out_res.open_pulse,
                      out_res.result_order, out_res.slot_index};
    assign m_tuser = out_res.action;
    assign m_tlast = out_res.last;

endmodule

/* hdl/lsaw_ctrl.sv */
// item sequencer: accept cycle, then waitlist drain and result hand-off
// depends on lsaw_pkg
module lsaw_ctrl
    import lsaw_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  lsaw_stat_t stat,
    output lsaw_cmd_t  cmd
);

    lsaw_state_t state_reg;
    lsaw_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.do_req = 1'b1;
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // wait for room for every result of this item
                if (stat.need <= stat.space) begin
                    cmd.do_drain = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
        endcase
    end

endmodule

/* hdl/lsaw_dp.sv */
// slot bank, waitlist memory and per-item result staging
// depends on lsaw_pkg, driven by lsaw_ctrl commands
module lsaw_dp
    import lsaw_pkg::*;
#(
    parameter int SLOTS      = 4,
    parameter int WAIT_DEPTH = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  lsaw_cmd_t          cmd,
    input  lsaw_cfg_t          cfg,
    input  logic [REQ_W-1:0]   in_req,
    input  logic [ORDER_W-1:0] in_order,
    output logic [1:0]         push_need,
    output lsaw_res_t          push_res0,
    output lsaw_res_t          push_res1
);

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int HW = $clog2(WAIT_DEPTH);
    localparam int CW = $clog2(WAIT_DEPTH + 1);

    logic                busy_reg  [SLOTS];
    logic                busy_next [SLOTS];
    logic [ORDER_W-1:0]  order_reg [SLOTS];
    logic [ORDER_W-1:0]  order_next[SLOTS];
    logic [AGE_W-1:0]    age_reg   [SLOTS];
    logic [AGE_W-1:0]    age_next  [SLOTS];

    logic [HW-1:0]       head_reg, head_next;
    logic [HW-1:0]       tail_reg, tail_next;
    logic [CW-1:0]       count_reg, count_next;

    lsaw_res_t           pend_reg, pend_next;
    logic                pend_valid_reg, pend_valid_next;
    logic                bypass_reg, bypass_next;
    logic [ORDER_W-1:0]  rd_data_reg;
    logic [ORDER_W-1:0]  wait_mem [WAIT_DEPTH];
    logic                push_wr;

    logic [SLOTS-1:0]    free_vec, exp_vec, match_vec;
    logic                free_found, exp_found, match_found, slot_found;
    logic [SW-1:0]       free_idx, exp_idx, match_idx, slot_idx;
    logic                drain_go;
    logic [ORDER_W-1:0]  drain_order;
    lsaw_res_t           drain_res;

    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            free_vec[i]  = (i < int'(cfg.lockers)) && !busy_reg[i];
            exp_vec[i]   = (i < int'(cfg.lockers)) && (age_reg[i] > cfg.lease);
            match_vec[i] = (i < int'(cfg.lockers)) && busy_reg[i]
                           && (order_reg[i] == in_order);
        end
    end

    // lowest set bit of each search vector
    always_comb begin
        free_found  = 1'b0;
        exp_found   = 1'b0;
        match_found = 1'b0;
        free_idx    = '0;
        exp_idx     = '0;
        match_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (free_vec[i]) begin
                free_found = 1'b1;
                free_idx   = SW'(i);
            end
            if (exp_vec[i]) begin
                exp_found = 1'b1;
                exp_idx   = SW'(i);
            end
            if (match_vec[i]) begin
                match_found = 1'b1;
                match_idx   = SW'(i);
            end
        end
    end

    assign slot_found  = free_found || exp_found;
    assign slot_idx    = free_found ? free_idx : exp_idx;
    assign drain_go    = (count_reg != '0) && slot_found;
    assign drain_order = bypass_reg ? pend_reg.result_order : rd_data_reg;

    always_comb begin
        drain_res              = '0;
        drain_res.action       = ACT_ASSIGNED;
        drain_res.slot_index   = SLOT_OUT_W'(slot_idx);
        drain_res.result_order = drain_order;
        drain_res.open_pulse   = 1'b1;
        drain_res.notify       = 1'b1;
        drain_res.last         = 1'b1;
    end

    always_comb begin
        push_res0      = pend_valid_reg ? pend_reg : drain_res;
        push_res0.last = pend_valid_reg ? !drain_go : 1'b1;
        push_res1      = drain_res;
        push_need      = {1'b0, pend_valid_reg} + {1'b0, drain_go};
    end

    always_comb begin
        busy_next       = busy_reg;
        order_next      = order_reg;
        age_next        = age_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        bypass_next     = bypass_reg;
        push_wr         = 1'b0;

        if (cmd.do_req) begin
            pend_next              = '0;
            pend_next.result_order = in_order;
            pend_valid_next        = 1'b0;
            bypass_next            = 1'b0;
            case (in_req)
                REQ_TICK: begin
                    for (int i = 0; i < SLOTS; i++) begin
                        if (busy_reg[i] && age_reg[i] != AGE_MAX) begin
                            age_next[i] = age_reg[i] + AGE_W'(1);
                        end
                    end
                end
                REQ_ASSIGN: begin
                    pend_valid_next = 1'b1;
                    if (match_found) begin
                        busy_next[match_idx] = 1'b0;
                        pend_next.action     = ACT_RELEASED;
                        pend_next.slot_index = SLOT_OUT_W'(match_idx);
                        pend_next.open_pulse = 1'b1;
                    end else if (slot_found) begin
                        busy_next[slot_idx]  = 1'b1;
                        order_next[slot_idx] = in_order;
                        age_next[slot_idx]   = '0;
                        pend_next.action     = ACT_ASSIGNED;
                        pend_next.slot_index = SLOT_OUT_W'(slot_idx);
                        pend_next.open_pulse = 1'b1;
                        pend_next.notify     = 1'b1;
                    end else if (count_reg == CW'(WAIT_DEPTH)) begin
                        pend_next.action = ACT_DROPPED;
                    end else begin
                        push_wr          = 1'b1;
                        bypass_next      = (count_reg == '0);
                        tail_next        = (tail_reg == HW'(WAIT_DEPTH - 1)) ? '0
                                           : tail_reg + HW'(1);
                        count_next       = count_reg + CW'(1);
                        pend_next.action = ACT_QUEUED;
                    end
                end
                REQ_RELEASE: begin
                    pend_valid_next = 1'b1;
                    if (match_found) begin
                        busy_next[match_idx] = 1'b0;
                        pend_next.action     = ACT_RELEASED;
                        pend_next.slot_index = SLOT_OUT_W'(match_idx);
                        pend_next.open_pulse = 1'b1;
                    end else begin
                        pend_next.action = ACT_NO_SLOT;
                    end
                end
                default: begin
                end
            endcase
        end

        if (cmd.do_drain) begin
            pend_valid_next = 1'b0;
            if (drain_go) begin
                busy_next[slot_idx]  = 1'b1;
                order_next[slot_idx] = drain_order;
                age_next[slot_idx]   = '0;
                head_next            = (head_reg == HW'(WAIT_DEPTH - 1)) ? '0
                                       : head_reg + HW'(1);
                count_next           = count_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SLOTS; i++) begin
                busy_reg[i] <= 1'b0;
                age_reg[i]  <= '0;
            end
            head_reg       <= '0;
            tail_reg       <= '0;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
        end else begin
            busy_reg       <= busy_next;
            age_reg        <= age_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        order_reg  <= order_next;
        pend_reg   <= pend_next;
        bypass_reg <= bypass_next;
    end

    // waitlist storage, head read on every accepted beat
    always_ff @(posedge aclk) begin
        if (push_wr) begin
            wait_mem[tail_reg] <= in_order;
        end
        if (cmd.do_req) begin
            rd_data_reg <= wait_mem[head_reg];
        end
    end

endmodule

/* hdl/lsaw_outq.sv */
// two-entry result queue in front of the output channel
// depends on lsaw_pkg
module lsaw_outq
    import lsaw_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push_en,
    input  logic [1:0] push_cnt,
    input  lsaw_res_t  push_res0,
    input  lsaw_res_t  push_res1,
    output logic [1:0] space,
    output logic       m_valid,
    input  logic       m_ready,
    output lsaw_res_t  m_res
);

    lsaw_res_t  ent_reg [2];
    logic       head_reg, head_next;
    logic [1:0] count_reg, count_next;
    logic       wr0, pop;
    logic [1:0] add;

    assign m_valid = (count_reg != 2'd0);
    assign m_res   = ent_reg[head_reg];
    assign space   = 2'd2 - count_reg;
    assign pop     = m_valid && m_ready;
    assign wr0     = head_reg ^ count_reg[0];
    assign add     = push_en ? push_cnt : 2'd0;

    always_comb begin
        count_next = count_reg + add - {1'b0, pop};
        head_next  = head_reg ^ pop;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= 1'b0;
            count_reg <= 2'd0;
        end else begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (add != 2'd0) begin
            ent_reg[wr0] <= push_res0;
        end
        if (add == 2'd2) begin
            ent_reg[~wr0] <= push_res1;
        end
    end

endmodule

/* hdl/lsaw_chk.sv */
// port-level checker for the lease slot allocator, bound to the top level
// depends on lsaw_pkg and the assertion macro header
`include "lease_slot_allocator_with_waitlist_top_defines.svh"

module lsaw_chk
    import lsaw_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [ACT_W-1:0]     m_tuser,
    input logic                 m_tlast,
    input logic                 m_tvalid,
    input logic                 m_tready
);

    `LSAW_ASSERT_NXT(a_one_item_at_a_time, aclk, aresetn, s_tvalid && s_tready, !s_tready, "input beat taken in back-to-back cycles")
    `LSAW_ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result beat changed")
    `LSAW_ASSERT_IMP(a_flags_match_action, aclk, aresetn, m_tvalid, (m_tdata[33] == (m_tuser == ACT_RELEASED || m_tuser == ACT_ASSIGNED)) && (m_tdata[34] == (m_tuser == ACT_ASSIGNED)), "open or notify flag disagrees with action")
    `LSAW_ASSERT_IMP(a_slot_zero_when_closed, aclk, aresetn, m_tvalid && !m_tdata[33], m_tdata[1:0] == 2'd0, "slot index set on a result without a slot")

endmodule

bind lease_slot_allocator_with_waitlist_top lsaw_chk u_chk (.*);
